/* hdl/hsv_pkg.sv */
// Package: constants and types shared by the HSV to RGB converter files.
package hsv_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int HUE_W       = 16;
    localparam int SAT_W       = 10;
    localparam int VAL_W       = 10;
    localparam int CHAN_W      = 8;

    // Hue reduction: add a multiple of 360 so the angle is positive, then
    // take the quotient by 360 through a reciprocal multiply.
    localparam int HUE_EXT_W   = HUE_W + 1;
    localparam int DEG_FULL    = 360;
    localparam int DEG_SECTOR  = 60;
    localparam int HUE_OFFSET  = DEG_FULL * 92;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_360   = (1 << RECIP_SHIFT) / DEG_FULL;
    localparam int QUOT_W      = 8;
    localparam int HUE_RED_W   = 9;
    localparam int REM_W       = 6;

    // Pipeline depth from input register to output register.
    localparam int N_STG       = 6;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

/* hdl/hsv_stream_if.sv */
// Interfaces: valid/ready stream channels for HSV input and RGB output.
interface hsv_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [hsv_pkg::HUE_W-1:0]    hue_deg;
    logic signed [hsv_pkg::SAT_W-1:0]    saturation;
    logic signed [hsv_pkg::VAL_W-1:0]    brightness;

    modport source (output valid, output hue_deg, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue_deg, input saturation, input brightness,
                    output ready);
endinterface

interface hsv_out_if;
    logic                                valid;
    logic                                ready;
    logic [hsv_pkg::CHAN_W-1:0]          red;
    logic [hsv_pkg::CHAN_W-1:0]          green;
    logic [hsv_pkg::CHAN_W-1:0]          blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hdl/hsv_tsel.sv */
// Channel term generation: p, q, t and value terms, routed by hue sector.
module hsv_tsel #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS
) (
    input  hsv_pkg::t_sector               i_sector,
    input  logic [hsv_pkg::REM_W-1:0]      i_rem,
    input  logic [FRAC_BITS:0]             i_sat,
    output logic [FRAC_BITS+5:0]           o_t_red,
    output logic [FRAC_BITS+5:0]           o_t_green,
    output logic [FRAC_BITS+5:0]           o_t_blue
);
    localparam int TW = FRAC_BITS + 6;

    logic [TW-1:0] one_w;
    logic [TW-1:0] full_w;
    logic [TW-1:0] sat_w;
    logic [TW-1:0] x_val;
    logic [TW-1:0] x_p;
    logic [TW-1:0] x_q;
    logic [TW-1:0] x_t;
    logic [hsv_pkg::REM_W-1:0] rem_c;

    always_comb begin
        one_w  = TW'(1) << FRAC_BITS;
        full_w = TW'(hsv_pkg::DEG_SECTOR) << FRAC_BITS;
        sat_w  = TW'(i_sat);
        rem_c  = hsv_pkg::REM_W'(hsv_pkg::DEG_SECTOR) - i_rem;
        x_val  = full_w;
        x_p    = TW'(hsv_pkg::DEG_SECTOR) * (one_w - sat_w);
        x_q    = full_w - sat_w * TW'(i_rem);
        x_t    = full_w - sat_w * TW'(rem_c);
    end

    always_comb begin
        unique case (i_sector)
            hsv_pkg::SEC_YEL_GRN: begin
                o_t_red = x_q;   o_t_green = x_val; o_t_blue = x_p;
            end
            hsv_pkg::SEC_GRN_CYN: begin
                o_t_red = x_p;   o_t_green = x_val; o_t_blue = x_t;
            end
            hsv_pkg::SEC_CYN_BLU: begin
                o_t_red = x_p;   o_t_green = x_q;   o_t_blue = x_val;
            end
            hsv_pkg::SEC_BLU_MAG: begin
                o_t_red = x_t;   o_t_green = x_p;   o_t_blue = x_val;
            end
            hsv_pkg::SEC_MAG_RED: begin
                o_t_red = x_val; o_t_green = x_p;   o_t_blue = x_q;
            end
            default: begin
                o_t_red = x_val; o_t_green = x_t;   o_t_blue = x_p;
            end
        endcase
    end
endmodule

/* hdl/hsv_to_rgb_converter.sv */
// Top level: six-stage pipelined HSV to 8-bit RGB converter.
//
//  channel  dir  modport  beat payload
//  i_pix    in   sink     hue_deg[15:0] s, saturation[9:0] s, brightness[9:0] s
//  o_pix    out  source   red[7:0], green[7:0], blue[7:0]
//
// One beat per clock sustained while o_pix.ready stays high; each beat passes
// through the six register stages (reciprocal multiply, remainder fix,
// sector split, term generation, value multiply, scale) to the output.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and the input keeps accepting while a result waits,
// until all six stages hold a beat; then i_pix.ready drops with o_pix.ready.
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = hsv_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsv_in_if.sink      i_pix,
    hsv_out_if.source   o_pix
);
    localparam int NS  = hsv_pkg::N_STG;
    localparam int W1  = FRAC_BITS + 1;          // 0..ONE
    localparam int TW  = FRAC_BITS + 6;          // up to 60*ONE
    localparam int XW  = 2 * FRAC_BITS + 7;      // up to 60*ONE*ONE
    localparam int YW  = XW + 5;                 // times 17
    localparam int UW  = (W1 > hsv_pkg::SAT_W - 1) ? W1 : hsv_pkg::SAT_W - 1;
    localparam int HW  = hsv_pkg::HUE_EXT_W;
    localparam int PW  = HW + hsv_pkg::RECIP_W;
    localparam int CW  = hsv_pkg::CHAN_W;
    localparam int SH  = 2 * FRAC_BITS + 2;      // 255/60 = 17/4

    // stage valid bits and advance enables
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_pix.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_pix.valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // clamp of a signed fraction field to 0..ONE
    function automatic logic [W1-1:0] clamp_unit(input logic [hsv_pkg::SAT_W-1:0] x);
        logic [UW-1:0] ux;
        logic [UW-1:0] one_u;
        ux    = UW'(x[hsv_pkg::SAT_W-2:0]);
        one_u = UW'(1) << FRAC_BITS;
        if (x[hsv_pkg::SAT_W-1])  clamp_unit = '0;
        else if (ux > one_u)      clamp_unit = W1'(one_u);
        else                      clamp_unit = W1'(ux);
    endfunction

    // ---- stage 1: offset hue positive, reciprocal multiply, clamp S and V
    logic [HW-1:0]  n_u;
    logic [PW-1:0]  n_prod;
    logic [HW-1:0]  r_u1;
    logic [hsv_pkg::QUOT_W-1:0] r_q1;
    logic [W1-1:0]  r_s1, r_v1;

    always_comb begin
        n_u    = {i_pix.hue_deg[hsv_pkg::HUE_W-1], i_pix.hue_deg}
                 + HW'(hsv_pkg::HUE_OFFSET);
        n_prod = PW'(n_u) * PW'(hsv_pkg::RECIP_360);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_u1 <= n_u;
            r_q1 <= n_prod[hsv_pkg::RECIP_SHIFT +: hsv_pkg::QUOT_W];
            r_s1 <= clamp_unit(i_pix.saturation);
            r_v1 <= clamp_unit(i_pix.brightness);
        end
    end

    // ---- stage 2: remainder mod 360; quotient may be one short
    logic [HW-1:0]  n_rem;
    logic [hsv_pkg::HUE_RED_W-1:0] n_hr;
    logic [hsv_pkg::HUE_RED_W-1:0] r_hr2;
    logic [W1-1:0]  r_s2, r_v2;

    always_comb begin
        n_rem = r_u1 - HW'(r_q1) * HW'(hsv_pkg::DEG_FULL);
        if (n_rem >= HW'(hsv_pkg::DEG_FULL))
            n_hr = hsv_pkg::HUE_RED_W'(n_rem - HW'(hsv_pkg::DEG_FULL));
        else
            n_hr = hsv_pkg::HUE_RED_W'(n_rem);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_hr2 <= n_hr;
            r_s2  <= r_s1;
            r_v2  <= r_v1;
        end
    end

    // ---- stage 3: sector and remainder within sector
    localparam int HRW = hsv_pkg::HUE_RED_W;
    hsv_pkg::t_sector n_sec;
    logic [HRW-1:0] n_base;
    hsv_pkg::t_sector r_sec3;
    logic [hsv_pkg::REM_W-1:0] r_rem3;
    logic [W1-1:0]  r_s3, r_v3;

    always_comb begin
        if (r_hr2 >= HRW'(5 * hsv_pkg::DEG_SECTOR)) begin
            n_sec = hsv_pkg::SEC_MAG_RED; n_base = HRW'(5 * hsv_pkg::DEG_SECTOR);
        end else if (r_hr2 >= HRW'(4 * hsv_pkg::DEG_SECTOR)) begin
            n_sec = hsv_pkg::SEC_BLU_MAG; n_base = HRW'(4 * hsv_pkg::DEG_SECTOR);
        end else if (r_hr2 >= HRW'(3 * hsv_pkg::DEG_SECTOR)) begin
            n_sec = hsv_pkg::SEC_CYN_BLU; n_base = HRW'(3 * hsv_pkg::DEG_SECTOR);
        end else if (r_hr2 >= HRW'(2 * hsv_pkg::DEG_SECTOR)) begin
            n_sec = hsv_pkg::SEC_GRN_CYN; n_base = HRW'(2 * hsv_pkg::DEG_SECTOR);
        end else if (r_hr2 >= HRW'(hsv_pkg::DEG_SECTOR)) begin
            n_sec = hsv_pkg::SEC_YEL_GRN; n_base = HRW'(hsv_pkg::DEG_SECTOR);
        end else begin
            n_sec = hsv_pkg::SEC_RED_YEL; n_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_sec3 <= n_sec;
            r_rem3 <= hsv_pkg::REM_W'(r_hr2 - n_base);
            r_s3   <= r_s2;
            r_v3   <= r_v2;
        end
    end

    // ---- stage 4: p/q/t/value terms, routed to channels
    logic [TW-1:0] n_tr, n_tg, n_tb;
    logic [TW-1:0] r_tr4, r_tg4, r_tb4;
    logic [W1-1:0] r_v4;

    hsv_tsel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_tsel (
        .i_sector  (r_sec3),
        .i_rem     (r_rem3),
        .i_sat     (r_s3),
        .o_t_red   (n_tr),
        .o_t_green (n_tg),
        .o_t_blue  (n_tb)
    );

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_tr4 <= n_tr;
            r_tg4 <= n_tg;
            r_tb4 <= n_tb;
            r_v4  <= r_v3;
        end
    end

    // ---- stage 5: multiply by value; result is a multiple of 1/(60*ONE*ONE)
    logic [XW-1:0] r_xr5, r_xg5, r_xb5;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_xr5 <= XW'(r_v4) * XW'(r_tr4);
            r_xg5 <= XW'(r_v4) * XW'(r_tg4);
            r_xb5 <= XW'(r_v4) * XW'(r_tb4);
        end
    end

    // ---- stage 6: floor(x*255/(60*ONE*ONE)) = (x*17) >> (2F+2)
    logic [YW-1:0] n_yr, n_yg, n_yb;
    logic [CW-1:0] r_red, r_green, r_blue;

    always_comb begin
        n_yr = (YW'(r_xr5) << 4) + YW'(r_xr5);
        n_yg = (YW'(r_xg5) << 4) + YW'(r_xg5);
        n_yb = (YW'(r_xb5) << 4) + YW'(r_xb5);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_red   <= n_yr[SH +: CW];
            r_green <= n_yg[SH +: CW];
            r_blue  <= n_yb[SH +: CW];
        end
    end

    assign o_pix.valid = r_vld[NS-1];
    assign o_pix.red   = r_red;
    assign o_pix.green = r_green;
    assign o_pix.blue  = r_blue;
endmodule

/* hdl/hsv_check.sv */
// Checker: port-level assertions for the HSV to RGB converter, with bind.
module hsv_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    localparam int CNTW = $clog2(hsv_pkg::N_STG + 1);

    logic [CNTW-1:0] r_cnt;
    logic            acc_in;
    logic            acc_out;

    assign acc_in  = i_in_valid && i_in_ready;
    assign acc_out = i_out_valid && i_out_ready;

    // beats in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNTW'(acc_in) - CNTW'(acc_out);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(hsv_pkg::N_STG))
        else $error("more beats in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> !i_out_valid)
        else $error("output beat with nothing in flight");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output stage empty");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
endmodule

bind hsv_to_rgb_converter hsv_check u_hsv_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready)
);

/* tb/sv/tb_top.sv */
// Testbench: streams HSV pixels through the converter and checks every RGB beat.
module tb_top;

    // One pixel as offered on the input channel.
    typedef struct packed {
        logic signed [hsv_pkg::HUE_W-1:0] hue;
        logic signed [hsv_pkg::SAT_W-1:0] sat;
        logic signed [hsv_pkg::VAL_W-1:0] val;
    } t_pixel;

    // One converted pixel as seen on the output channel.
    typedef struct packed {
        logic [hsv_pkg::CHAN_W-1:0] red;
        logic [hsv_pkg::CHAN_W-1:0] green;
        logic [hsv_pkg::CHAN_W-1:0] blue;
    } t_rgb;

    localparam int RANDOM_PIXELS = 1300;
    localparam int TAIL_PIXELS   = 200;   // no idling on either side once this few remain
    localparam int STALL_AT      = 200;   // output beats seen before the long stall
    localparam int LONG_STALL    = 48;    // long enough to back the pipe up into the input
    localparam int IDLE_LIMIT    = 1000;  // cycles with no beat on either side

    logic i_clk;
    logic i_rst_n;

    hsv_in_if  pix_in ();
    hsv_out_if pix_out ();

    hsv_to_rgb_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    t_pixel pixels_to_send[$];   // filled up front, drained by the driver
    t_rgb   rgb_expected[$];     // one entry per accepted input beat, oldest first

    int pixels_total;
    int beats_in;
    int beats_out;
    int errors;
    int n_directed;
    int n_shaped;
    int n_raw;
    int src_gap_left;
    int snk_gap_left;
    int stall_left;
    bit stall_done;
    bit tail_phase;
    int quiet_cycles;

    // Appends one pixel to the stimulus list.
    function automatic void queue_pixel(input t_pixel px);
        pixels_to_send.insert(pixels_to_send.size(), px);
    endfunction

    // Exact fixed-point conversion. Every channel quantity is held as a
    // multiple of 1/(60 * ONE * ONE) so the only division is the final scale.
    function automatic t_rgb rgb_from_hsv(input t_pixel px);
        longint  one;
        longint  den;
        longint  s;
        longint  v;
        longint  r;
        longint  xv;
        longint  xp;
        longint  xq;
        longint  xt;
        longint  xr;
        longint  xg;
        longint  xb;
        int      hue_red;
        hsv_pkg::t_sector sector;
        t_rgb    rgb;
        one = longint'(1) << hsv_pkg::FRAC_BITS;
        den = 60 * one * one;
        // Truncating remainder, then fold negatives up into 0..359.
        hue_red = int'(px.hue) % hsv_pkg::DEG_FULL;
        if (hue_red < 0) begin
            hue_red = hue_red + hsv_pkg::DEG_FULL;
        end
        // Clamp saturation and value to 0..ONE.
        s = longint'(px.sat);
        if (s < 0) begin
            s = 0;
        end else if (s > one) begin
            s = one;
        end
        v = longint'(px.val);
        if (v < 0) begin
            v = 0;
        end else if (v > one) begin
            v = one;
        end
        sector = hsv_pkg::t_sector'(3'(hue_red / hsv_pkg::DEG_SECTOR));
        r      = longint'(hue_red % hsv_pkg::DEG_SECTOR);
        xv = v * 60 * one;
        xp = v * 60 * (one - s);
        xq = v * (60 * one - s * r);
        xt = v * (60 * one - s * (60 - r));
        case (sector)
            hsv_pkg::SEC_YEL_GRN: begin
                xr = xq; xg = xv; xb = xp;
            end
            hsv_pkg::SEC_GRN_CYN: begin
                xr = xp; xg = xv; xb = xt;
            end
            hsv_pkg::SEC_CYN_BLU: begin
                xr = xp; xg = xq; xb = xv;
            end
            hsv_pkg::SEC_BLU_MAG: begin
                xr = xt; xg = xp; xb = xv;
            end
            hsv_pkg::SEC_MAG_RED: begin
                xr = xv; xg = xp; xb = xq;
            end
            default: begin
                xr = xv; xg = xt; xb = xp;
            end
        endcase
        rgb.red   = hsv_pkg::CHAN_W'((xr * 255) / den);
        rgb.green = hsv_pkg::CHAN_W'((xg * 255) / den);
        rgb.blue  = hsv_pkg::CHAN_W'((xb * 255) / den);
        return rgb;
    endfunction

    // Clock: period 10.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset, stimulus build-up and end of run.
    initial begin
        t_pixel     px;
        bit  [31:0] rnd;
        bit  [31:0] rnd2;
        int         kind;
        // Every input known from time zero.
        i_rst_n           = 1'b0;
        pix_in.valid      = 1'b0;
        pix_in.hue_deg    = '0;
        pix_in.saturation = '0;
        pix_in.brightness = '0;
        pix_out.ready     = 1'b0;

        // Directed pixels: primaries at each sector start, sector edges,
        // wrap-around and negative hues, hue extremes, and saturation or
        // value below zero and above one.
        queue_pixel('{16'sd0,      10'sd256,  10'sd256});
        queue_pixel('{16'sd60,     10'sd256,  10'sd256});
        queue_pixel('{16'sd120,    10'sd256,  10'sd256});
        queue_pixel('{16'sd180,    10'sd256,  10'sd256});
        queue_pixel('{16'sd240,    10'sd256,  10'sd256});
        queue_pixel('{16'sd300,    10'sd256,  10'sd256});
        queue_pixel('{16'sd359,    10'sd256,  10'sd256});
        queue_pixel('{16'sd360,    10'sd256,  10'sd256});
        queue_pixel('{-16'sd1,     10'sd256,  10'sd256});
        queue_pixel('{-16'sd360,   10'sd200,  10'sd200});
        queue_pixel('{-16'sd32768, 10'sd511,  10'sd511});
        queue_pixel('{16'sd32767,  -10'sd512, 10'sd511});
        queue_pixel('{16'sd30,     10'sd128,  -10'sd512});
        queue_pixel('{16'sd45,     10'sd257,  10'sd300});
        queue_pixel('{16'sd90,     -10'sd1,   10'sd255});
        queue_pixel('{16'sd59,     10'sd256,  10'sd256});
        queue_pixel('{16'sd119,    10'sd100,  10'sd200});
        queue_pixel('{16'sd179,    10'sd256,  10'sd1});
        queue_pixel('{16'sd239,    10'sd0,    10'sd256});
        queue_pixel('{16'sd299,    10'sd255,  10'sd255});
        queue_pixel('{-16'sd181,   10'sd128,  10'sd128});
        queue_pixel('{-16'sd32767, 10'sd0,    10'sd0});
        queue_pixel('{16'sd32400,  10'sd1,    10'sd256});
        queue_pixel('{-16'sd721,   10'sd256,  10'sd256});
        queue_pixel('{16'sd15,     10'sd256,  10'sd256});
        n_directed = pixels_to_send.size();

        // Random pixels: mostly in-range saturation/value over a few turns of
        // the hue circle, some with a raw hue, some with every field raw.
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            rnd  = $urandom();
            rnd2 = $urandom();
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                px.hue = 16'(int'($urandom_range(0, 2159)) - 1080);
                n_shaped++;
            end else begin
                px.hue = rnd[15:0];
                n_raw++;
            end
            if (kind < 8) begin
                px.sat = 10'($urandom_range(0, 256));
                px.val = 10'($urandom_range(0, 256));
            end else begin
                px.sat = rnd[25:16];
                px.val = rnd2[9:0];
            end
            queue_pixel(px);
        end
        pixels_total = pixels_to_send.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All input beats accepted, then all results in, then a further wait
        // so that a stray beat would still be caught.
        while (beats_in != pixels_total) @(posedge i_clk);
        while (rgb_expected.size() != 0) @(posedge i_clk);
        repeat (hsv_pkg::N_STG + 4) @(posedge i_clk);

        $display("summary: %0d pixels checked (%0d directed, %0d shaped hue, %0d raw hue)",
                 beats_out, n_directed, n_shaped, n_raw);
        $display("summary: output held off %0d cycles once to back up the pipe",
                 LONG_STALL);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        tail_phase <= (pixels_to_send.size() < TAIL_PIXELS);
    end

    // Driver: records the expectation of each accepted beat, then picks the
    // next beat, holds it while the block is stalled, or idles for a burst.
    always @(posedge i_clk) begin
        t_pixel nxt;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
            src_gap_left <= 0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                nxt.hue = pix_in.hue_deg;
                nxt.sat = pix_in.saturation;
                nxt.val = pix_in.brightness;
                rgb_expected.insert(rgb_expected.size(), rgb_from_hsv(nxt));
                beats_in++;
            end
            if (pix_in.valid && !pix_in.ready) begin
                // keep offering the same beat
            end else if (src_gap_left != 0) begin
                src_gap_left <= src_gap_left - 1;
                pix_in.valid <= 1'b0;
            end else if (pixels_to_send.size() == 0) begin
                pix_in.valid <= 1'b0;
            end else if (!tail_phase && stall_left == 0 && $urandom_range(0, 7) == 0) begin
                // idle burst: this cycle plus a random src_gap_left
                src_gap_left <= $urandom_range(0, 2);
                pix_in.valid <= 1'b0;
            end else begin
                nxt = pixels_to_send.pop_front();
                pix_in.hue_deg    <= nxt.hue;
                pix_in.saturation <= nxt.sat;
                pix_in.brightness <= nxt.val;
                pix_in.valid      <= 1'b1;
            end
        end
    end

    // Monitor: checks each output beat against the oldest expectation and
    // drives ready, with one long hold-off and short random bursts.
    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            snk_gap_left  <= 0;
            stall_left    <= 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                got.red   = pix_out.red;
                got.green = pix_out.green;
                got.blue  = pix_out.blue;
                beats_out++;
                if (rgb_expected.size() == 0) begin
                    $error("output beat with nothing expected: rgb %0d %0d %0d",
                           got.red, got.green, got.blue);
                    errors++;
                end else begin
                    want = rgb_expected.pop_front();
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, got.red);
                        errors++;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, got.green);
                        errors++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, got.blue);
                        errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left    <= stall_left - 1;
                pix_out.ready <= 1'b0;
            end else if (!stall_done && beats_out >= STALL_AT) begin
                // long hold-off: the pipe fills and the input gets stalled
                stall_done    <= 1'b1;
                stall_left    <= LONG_STALL - 1;
                pix_out.ready <= 1'b0;
            end else if (snk_gap_left != 0) begin
                snk_gap_left  <= snk_gap_left - 1;
                pix_out.ready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
                snk_gap_left  <= $urandom_range(0, 2);
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

/* files.f */
hdl/hsv_pkg.sv
hdl/hsv_stream_if.sv
hdl/hsv_tsel.sv
hdl/hsv_to_rgb_converter.sv
hdl/hsv_check.sv
tb/sv/tb_top.sv
